### hdl/isv_pkg.sv
// Shared types, character codes and small arithmetic helpers for the ISBN validator.
`timescale 1ns / 1ps

package isv_pkg;

  // Characters of interest
  localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_X_UPPER = 8'h58;
  localparam logic [7:0] CHAR_X_LOWER = 8'h78;

  // Count and position limits
  localparam logic [3:0] COUNT_SAT     = 4'd14;
  localparam logic [3:0] LEN_TEN       = 4'd10;
  localparam logic [3:0] LEN_THIRTEEN  = 4'd13;
  localparam logic [3:0] LAST_BODY_POS = 4'd9;
  localparam logic [3:0] PREFIX_POS    = 4'd3;
  localparam logic [3:0] FIRST_POS     = 4'd1;
  localparam logic [3:0] FOURTH_POS    = 4'd4;

  // Value of X in the tenth position, weighted by ten
  localparam logic [6:0] X_WEIGHTED = 7'd100;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_TEN      = 2'd1,
    KIND_THIRTEEN = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LENGTH   = 2'd1,
    ERR_TEN      = 2'd2,
    ERR_THIRTEEN = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    LANG_ENGLISH = 3'd0,
    LANG_FRENCH  = 3'd1,
    LANG_GERMAN  = 3'd2,
    LANG_JAPAN   = 3'd3,
    LANG_RUSSIAN = 3'd4,
    LANG_CHINA   = 3'd5,
    LANG_OTHER   = 3'd6
  } lang_t;

  // Running state of one ISBN string
  typedef struct packed {
    logic [3:0] kept_count;
    logic [3:0] sum_mod_eleven;
    logic [3:0] sum_mod_ten;
    logic       ten_form_bad;
    logic       thirteen_form_bad;
    logic [9:0] prefix_acc;
    logic [7:0] first_kept_char;
    logic [7:0] fourth_kept_char;
    logic [7:0] last_kept_char;
  } isv_state_t;

  // One result beat
  typedef struct packed {
    logic       valid_res;
    kind_t      kind;
    err_t       error_code;
    logic [7:0] check_char;
    logic [9:0] prefix_value;
    lang_t      language_group;
  } isv_result_t;

  // Remainder mod 11 for values below 128: reciprocal 187/2048 is exact here
  function automatic logic [3:0] mod11_small(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [7:0]  q11;
    logic [7:0]  r;
    prod = 15'(v) * 15'd187;
    q    = prod[14:11];
    q11  = 8'(q) * 8'd11;
    r    = 8'(v) - q11;
    return r[3:0];
  endfunction

  // Remainder mod 10 for values below 64: reciprocal 205/2048 is exact here
  function automatic logic [3:0] mod10_small(input logic [5:0] v);
    logic [13:0] prod;
    logic [2:0]  q;
    logic [6:0]  q10;
    logic [6:0]  r;
    prod = 14'(v) * 14'd205;
    q    = prod[13:11];
    q10  = 7'(q) * 7'd10;
    r    = 7'(v) - q10;
    return r[3:0];
  endfunction

  // Language group from a registration group character
  function automatic lang_t group_of(input logic [7:0] c);
    lang_t g;
    case (c)
      8'h30, 8'h31: g = LANG_ENGLISH;
      8'h32:        g = LANG_FRENCH;
      8'h33:        g = LANG_GERMAN;
      8'h34:        g = LANG_JAPAN;
      8'h35:        g = LANG_RUSSIAN;
      8'h37:        g = LANG_CHINA;
      default:      g = LANG_OTHER;
    endcase
    return g;
  endfunction

endpackage

### hdl/isv_step.sv
// Per-character update of the checksum state and result formation at the end mark.
`timescale 1ns / 1ps

module isv_step (
  input  isv_pkg::isv_state_t  state,
  input  logic [7:0]           ch,
  input  logic                 last,
  output isv_pkg::isv_state_t  state_next,
  output isv_pkg::isv_result_t result
);

  logic       keep;
  logic       dig;
  logic       is_x;
  logic [7:0] diff;
  logic [3:0] d;
  logic [3:0] pos;
  logic [7:0] prod;
  logic [6:0] v11;
  logic [5:0] d3;
  logic [5:0] v10;
  logic [9:0] prefix_times10;
  isv_pkg::isv_state_t upd;

  // Classify the character
  assign keep = (ch != isv_pkg::CHAR_HYPHEN) && (ch != isv_pkg::CHAR_SPACE);
  assign dig  = (ch >= isv_pkg::CHAR_ZERO) && (ch <= isv_pkg::CHAR_NINE);
  assign is_x = (ch == isv_pkg::CHAR_X_UPPER) || (ch == isv_pkg::CHAR_X_LOWER);
  assign diff = ch - isv_pkg::CHAR_ZERO;
  assign d    = dig ? diff[3:0] : 4'd0;
  assign pos  = state.kept_count + 4'd1;

  // Weighted terms for both checks
  assign prod = 8'(d) * 8'(pos);
  assign v11  = 7'(state.sum_mod_eleven) + ((is_x && !dig) ? isv_pkg::X_WEIGHTED : prod[6:0]);
  assign d3   = 6'({d, 1'b0}) + 6'(d);
  assign v10  = 6'(state.sum_mod_ten) + (pos[0] ? 6'(d) : d3);
  assign prefix_times10 = {state.prefix_acc[6:0], 3'b000} + {state.prefix_acc[8:0], 1'b0}
                        + 10'(d);

  // Fold the kept character into the state
  always_comb begin
    upd = state;
    if (keep) begin
      if (pos <= isv_pkg::LAST_BODY_POS) begin
        if (dig) upd.sum_mod_eleven = isv_pkg::mod11_small(v11);
        else     upd.ten_form_bad   = 1'b1;
      end else if (pos == isv_pkg::LEN_TEN) begin
        if (dig || is_x) upd.sum_mod_eleven = isv_pkg::mod11_small(v11);
        else             upd.ten_form_bad   = 1'b1;
      end
      if (pos <= isv_pkg::LEN_THIRTEEN) begin
        if (dig) upd.sum_mod_ten       = isv_pkg::mod10_small(v10);
        else     upd.thirteen_form_bad = 1'b1;
      end
      if ((pos <= isv_pkg::PREFIX_POS) && dig) upd.prefix_acc = prefix_times10;
      if (pos == isv_pkg::FIRST_POS)  upd.first_kept_char  = ch;
      if (pos == isv_pkg::FOURTH_POS) upd.fourth_kept_char = ch;
      upd.last_kept_char = ch;
      if (state.kept_count < isv_pkg::COUNT_SAT) upd.kept_count = pos;
    end
  end

  // Form the result from the updated state
  always_comb begin
    result.valid_res      = 1'b0;
    result.kind           = isv_pkg::KIND_NONE;
    result.error_code     = isv_pkg::ERR_LENGTH;
    result.check_char     = upd.last_kept_char;
    result.prefix_value   = 10'd0;
    result.language_group = isv_pkg::LANG_OTHER;
    if (upd.kept_count == isv_pkg::LEN_TEN) begin
      result.kind = isv_pkg::KIND_TEN;
      if (!upd.ten_form_bad && (upd.sum_mod_eleven == 4'd0)) begin
        result.valid_res      = 1'b1;
        result.error_code     = isv_pkg::ERR_NONE;
        result.language_group = isv_pkg::group_of(upd.first_kept_char);
      end else begin
        result.error_code = isv_pkg::ERR_TEN;
      end
    end else if (upd.kept_count == isv_pkg::LEN_THIRTEEN) begin
      result.kind = isv_pkg::KIND_THIRTEEN;
      if (!upd.thirteen_form_bad && (upd.sum_mod_ten == 4'd0)) begin
        result.valid_res      = 1'b1;
        result.error_code     = isv_pkg::ERR_NONE;
        result.prefix_value   = upd.prefix_acc;
        result.language_group = isv_pkg::group_of(upd.fourth_kept_char);
      end else begin
        result.error_code = isv_pkg::ERR_THIRTEEN;
      end
    end
  end

  // Clear after the end mark
  assign state_next = last ? '0 : upd;

endmodule

### hdl/isbn_stream_validator.sv
// Top level: streaming ISBN-10 / ISBN-13 check-digit validator.
// Path: an end-mark beat is accepted into the input register, then its result is
//   captured in the result register.
// Throughput: one character per cycle, save for an end mark facing a full output.
// A waiting result does not stall non-final characters; only a second end mark waits.
// Reset (synchronous, active high) clears the checksum state and both valid flags.
`timescale 1ns / 1ps

module isbn_stream_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       end_mark,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       valid_res,
  output logic [1:0] kind,
  output logic [1:0] error_code,
  output logic [7:0] check_char,
  output logic [9:0] prefix_value,
  output logic [2:0] language_group
);

  logic                 s1_valid;
  logic [7:0]           s1_char;
  logic                 s1_last;
  logic                 s1_go;
  logic                 out_free;
  isv_pkg::isv_state_t  state;
  isv_pkg::isv_state_t  state_next;
  isv_pkg::isv_result_t result;

  isv_step u_step (
    .state      (state),
    .ch         (s1_char),
    .last       (s1_last),
    .state_next (state_next),
    .result     (result)
  );

  // Handshake: a held beat advances unless it is an end mark facing a full output
  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= char_in;
      s1_last <= end_mark;
    end
  end

  // Checksum state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      valid_res      <= result.valid_res;
      kind           <= result.kind;
      error_code     <= result.error_code;
      check_char     <= result.check_char;
      prefix_value   <= result.prefix_value;
      language_group <= result.language_group;
    end
  end

endmodule

### bench/tb_top.sv
// Self-checking bench for the ISBN stream validator: random ISBN text, predicted results.
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int PHASE_BEATS  = 325;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  // Predicts results from accepted characters and checks the output beats
  class isbn_scoreboard;
    logic [3:0]  n_kept;
    logic [3:0]  s11;
    logic [3:0]  s10;
    bit          bad10;
    bit          bad13;
    logic [9:0]  pfx;
    logic [7:0]  c_first;
    logic [7:0]  c_fourth;
    logic [7:0]  c_last;
    isv_pkg::isv_result_t want_q[$];
    int unsigned errors;

    function new();
      clear_string();
      errors = 0;
    endfunction

    function void clear_string();
      n_kept   = '0;
      s11      = '0;
      s10      = '0;
      bad10    = 1'b0;
      bad13    = 1'b0;
      pfx      = '0;
      c_first  = '0;
      c_fourth = '0;
      c_last   = '0;
    endfunction

    function isv_pkg::lang_t lang_for_char(logic [7:0] c);
      isv_pkg::lang_t g;
      case (c)
        isv_pkg::CHAR_ZERO, isv_pkg::CHAR_ZERO + 8'd1: g = isv_pkg::LANG_ENGLISH;
        isv_pkg::CHAR_ZERO + 8'd2:                     g = isv_pkg::LANG_FRENCH;
        isv_pkg::CHAR_ZERO + 8'd3:                     g = isv_pkg::LANG_GERMAN;
        isv_pkg::CHAR_ZERO + 8'd4:                     g = isv_pkg::LANG_JAPAN;
        isv_pkg::CHAR_ZERO + 8'd5:                     g = isv_pkg::LANG_RUSSIAN;
        isv_pkg::CHAR_ZERO + 8'd7:                     g = isv_pkg::LANG_CHINA;
        default:                                       g = isv_pkg::LANG_OTHER;
      endcase
      return g;
    endfunction

    // Advance the running sums on one accepted character; queue a result on the end mark
    function void note_beat(logic [7:0] c, logic last);
      int          pos;
      int          d;
      bit          dig;
      isv_pkg::isv_result_t r;
      if (c != isv_pkg::CHAR_HYPHEN && c != isv_pkg::CHAR_SPACE) begin
        pos = int'(n_kept) + 1;
        dig = (c >= isv_pkg::CHAR_ZERO) && (c <= isv_pkg::CHAR_NINE);
        d   = dig ? int'(c - isv_pkg::CHAR_ZERO) : 0;
        if (pos <= int'(isv_pkg::LAST_BODY_POS)) begin
          if (dig) s11 = 4'((int'(s11) + d * pos) % 11);
          else bad10 = 1'b1;
        end else if (pos == int'(isv_pkg::LEN_TEN)) begin
          if (dig) s11 = 4'((int'(s11) + d * 10) % 11);
          else if (c == isv_pkg::CHAR_X_UPPER || c == isv_pkg::CHAR_X_LOWER)
            s11 = 4'((int'(s11) + int'(isv_pkg::X_WEIGHTED)) % 11);
          else bad10 = 1'b1;
        end
        if (pos <= int'(isv_pkg::LEN_THIRTEEN)) begin
          if (dig) s10 = 4'((int'(s10) + ((pos % 2 == 1) ? d : 3 * d)) % 10);
          else bad13 = 1'b1;
        end
        if (pos <= int'(isv_pkg::PREFIX_POS) && dig) pfx = 10'(int'(pfx) * 10 + d);
        if (pos == int'(isv_pkg::FIRST_POS)) c_first = c;
        if (pos == int'(isv_pkg::FOURTH_POS)) c_fourth = c;
        c_last = c;
        if (n_kept < isv_pkg::COUNT_SAT) n_kept = n_kept + 4'd1;
      end
      if (!last) return;
      r.valid_res      = 1'b0;
      r.kind           = isv_pkg::KIND_NONE;
      r.error_code     = isv_pkg::ERR_LENGTH;
      r.check_char     = c_last;
      r.prefix_value   = '0;
      r.language_group = isv_pkg::LANG_OTHER;
      if (n_kept == isv_pkg::LEN_TEN) begin
        r.kind = isv_pkg::KIND_TEN;
        if (!bad10 && s11 == 4'd0) begin
          r.valid_res      = 1'b1;
          r.error_code     = isv_pkg::ERR_NONE;
          r.language_group = lang_for_char(c_first);
        end else begin
          r.error_code = isv_pkg::ERR_TEN;
        end
      end else if (n_kept == isv_pkg::LEN_THIRTEEN) begin
        r.kind = isv_pkg::KIND_THIRTEEN;
        if (!bad13 && s10 == 4'd0) begin
          r.valid_res      = 1'b1;
          r.error_code     = isv_pkg::ERR_NONE;
          r.prefix_value   = pfx;
          r.language_group = lang_for_char(c_fourth);
        end else begin
          r.error_code = isv_pkg::ERR_THIRTEEN;
        end
      end
      want_q.insert(want_q.size(), r);
      clear_string();
    endfunction

    // Compare one output beat with the oldest expected result
    function void check_result(isv_pkg::isv_result_t got);
      isv_pkg::isv_result_t want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: valid=%0d kind=%0d err=%0d chk=%02h pfx=%0d lang=%0d",
                   got.valid_res, got.kind, got.error_code, got.check_char,
                   got.prefix_value, got.language_group);
        return;
      end
      want = want_q.pop_front();
      if (got.valid_res !== want.valid_res || got.kind !== want.kind ||
          got.error_code !== want.error_code || got.check_char !== want.check_char ||
          got.prefix_value !== want.prefix_value ||
          got.language_group !== want.language_group) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("mismatch exp: valid=%0d kind=%0d err=%0d chk=%02h pfx=%0d lang=%0d",
                   want.valid_res, want.kind, want.error_code, want.check_char,
                   want.prefix_value, want.language_group);
          $display("         got: valid=%0d kind=%0d err=%0d chk=%02h pfx=%0d lang=%0d",
                   got.valid_res, got.kind, got.error_code, got.check_char,
                   got.prefix_value, got.language_group);
        end
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] char_in   = 8'h00;
  logic       end_mark  = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       valid_res;
  logic [1:0] kind;
  logic [1:0] error_code;
  logic [7:0] check_char;
  logic [9:0] prefix_value;
  logic [2:0] language_group;

  isbn_scoreboard sb;
  logic [7:0]     text_q[$];
  int             beats_sent     = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             hold_left      = 0;
  int             quiet;

  isbn_stream_validator u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_in        (char_in),
    .end_mark       (end_mark),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .valid_res      (valid_res),
    .kind           (kind),
    .error_code     (error_code),
    .check_char     (check_char),
    .prefix_value   (prefix_value),
    .language_group (language_group)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Drive the result ready: long hold-off first, else random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Observe both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_beat(char_in, end_mark);
      if (out_valid && out_ready)
        sb.check_result({valid_res, kind, error_code, check_char, prefix_value,
                         language_group});
    end
  end

  // End the run when nothing moves for too long
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Offer one character and hold it until accepted
  task automatic send_beat(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    end_mark <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
  endtask

  function automatic void load_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.insert(text_q.size(), s[i]);
  endfunction

  function automatic logic [7:0] pick_sep();
    return $urandom_range(1) ? isv_pkg::CHAR_HYPHEN : isv_pkg::CHAR_SPACE;
  endfunction

  // Nine random digits plus the matching ISBN-10 check character
  function automatic void build_ten();
    int sum;
    int d;
    text_q.delete();
    sum = 0;
    for (int i = 1; i <= 9; i++) begin
      d = $urandom_range(9);
      text_q.insert(text_q.size(), isv_pkg::CHAR_ZERO + 8'(d));
      sum += d * i;
    end
    sum = sum % 11;
    if (sum == 10)
      text_q.insert(text_q.size(),
                    $urandom_range(1) ? isv_pkg::CHAR_X_UPPER : isv_pkg::CHAR_X_LOWER);
    else text_q.insert(text_q.size(), isv_pkg::CHAR_ZERO + 8'(sum));
  endfunction

  // Twelve digits, mostly behind a 978/979 prefix, plus the ISBN-13 check digit
  function automatic void build_thirteen();
    int sum;
    int d;
    int sel;
    text_q.delete();
    sum = 0;
    sel = $urandom_range(2);
    for (int i = 1; i <= 12; i++) begin
      if (i <= 3 && sel < 2) d = (i == 1) ? 9 : (i == 2) ? 7 : (sel == 0 ? 8 : 9);
      else d = $urandom_range(9);
      text_q.insert(text_q.size(), isv_pkg::CHAR_ZERO + 8'(d));
      sum += (i % 2 == 1) ? d : 3 * d;
    end
    text_q.insert(text_q.size(), isv_pkg::CHAR_ZERO + 8'((10 - sum % 10) % 10));
  endfunction

  function automatic void build_noise(int len);
    text_q.delete();
    repeat (len) text_q.insert(text_q.size(), 8'($urandom_range(255)));
  endfunction

  // Digits with an occasional X, any length up to well past saturation
  function automatic void build_digit_run(int len);
    text_q.delete();
    repeat (len) begin
      if ($urandom_range(99) < 5) text_q.insert(text_q.size(), isv_pkg::CHAR_X_UPPER);
      else text_q.insert(text_q.size(), isv_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    end
  endfunction

  // Break a well-formed number in one of several ways
  function automatic void corrupt();
    int idx;
    logic [7:0] tmp;
    idx = $urandom_range(text_q.size() - 1);
    case ($urandom_range(4))
      0: text_q[idx] = isv_pkg::CHAR_ZERO + 8'($urandom_range(9));
      1: text_q[idx] = 8'($urandom_range(255));
      2: text_q.delete(idx);
      3: text_q.insert(idx, isv_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      default: begin
        if (idx > 0) begin
          tmp            = text_q[idx];
          text_q[idx]    = text_q[idx-1];
          text_q[idx-1]  = tmp;
        end
      end
    endcase
  endfunction

  function automatic void add_separators();
    repeat ($urandom_range(1, 4)) text_q.insert($urandom_range(text_q.size()), pick_sep());
  endfunction

  function automatic void build_random_string();
    int r;
    r = $urandom_range(99);
    if (r < 35) build_ten();
    else if (r < 70) build_thirteen();
    else if (r < 82) build_noise($urandom_range(16));
    else build_digit_run($urandom_range(1, 20));
    if (r < 70 && $urandom_range(99) < 30) corrupt();
    if ($urandom_range(99) < 50) add_separators();
    // End mark on a dropped character now and then
    if ($urandom_range(99) < 15 || text_q.size() == 0) text_q.insert(text_q.size(), pick_sep());
  endfunction

  initial begin
    int target;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty string, byte extremes, X check with trailing hyphen, ISBN-13
    text_q.delete();
    text_q.insert(text_q.size(), isv_pkg::CHAR_SPACE);
    send_text();
    text_q.delete();
    text_q.insert(text_q.size(), 8'h00);
    text_q.insert(text_q.size(), 8'hFF);
    send_text();
    load_text("080442957X-");
    send_text();
    load_text("9780306406157");
    send_text();

    // Random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      target = beats_sent + PHASE_BEATS;
      if (ph == 0) begin
        // Hold off the receiver while short strings pile up behind it
        hold_left = HOLD_CYCLES;
        repeat (40) begin
          build_noise($urandom_range(1, 3));
          send_text();
        end
      end
      while (beats_sent < target) begin
        build_random_string();
        send_text();
      end
    end

    // Drain
    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
